// ----- rtl/apo_pkg.sv -----
package apo_pkg;

	localparam int unsigned QW = 32;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	localparam logic signed [QW-1:0] Q_MAX = {1'b0, {(QW-1){1'b1}}};
	localparam logic signed [QW-1:0] Q_MIN = {1'b1, {(QW-1){1'b0}}};

	// per-axis test on the current beat
	typedef struct packed {
		logic signed [QW-1:0] ov;
		logic                 strict;
		logic                 dir;
	} apo_axis_t;

	// what is kept of the x and y beats
	typedef struct packed {
		logic signed [QW-1:0] ov;
		logic                 dir;
	} apo_stored_t;

	typedef struct packed {
		logic                 hit;
		logic [1:0]           push_axis;
		logic signed [QW-1:0] first_shift;
		logic signed [QW-1:0] second_shift;
		logic                 clear_first_velocity;
		logic                 clear_second_velocity;
	} apo_result_t;

endpackage

// ----- rtl/apo_axis.sv -----
module apo_axis (
	input  logic signed [apo_pkg::QW-1:0] first_min,
	input  logic signed [apo_pkg::QW-1:0] first_max,
	input  logic signed [apo_pkg::QW-1:0] first_pos,
	input  logic signed [apo_pkg::QW-1:0] second_min,
	input  logic signed [apo_pkg::QW-1:0] second_max,
	input  logic signed [apo_pkg::QW-1:0] second_pos,
	output apo_pkg::apo_axis_t            res
);
	import apo_pkg::*;

	logic signed [QW-1:0] hi;
	logic signed [QW-1:0] lo;
	logic signed [QW:0]   diff;

	always_comb begin
		hi   = (first_max < second_max) ? first_max : second_max;
		lo   = (first_min > second_min) ? first_min : second_min;
		diff = $signed({hi[QW-1], hi}) - $signed({lo[QW-1], lo});
		// clamp the 33-bit difference back into range
		if (diff[QW] != diff[QW-1]) begin
			res.ov = diff[QW] ? Q_MIN : Q_MAX;
		end else begin
			res.ov = diff[QW-1:0];
		end
		res.strict = (first_max > second_min) && (first_min < second_max);
		res.dir    = first_pos < second_pos;
	end

endmodule

// ----- rtl/apo_resolve.sv -----
module apo_resolve (
	input  logic                  dynamic,
	input  logic                  flag,
	input  apo_pkg::apo_stored_t  x_st,
	input  apo_pkg::apo_stored_t  y_st,
	input  apo_pkg::apo_axis_t    cur,
	output apo_pkg::apo_result_t  res
);
	import apo_pkg::*;

	logic                 hit;
	logic signed [QW-1:0] ovx;
	logic signed [QW-1:0] ovy;
	logic signed [QW-1:0] ovz;
	logic signed [QW-1:0] sel;
	logic signed [QW-1:0] half;
	logic signed [QW-1:0] neg_sel;
	logic                 d;
	logic [1:0]           pa;

	always_comb begin
		hit = flag && cur.strict;
		ovx = $signed(x_st.ov);
		ovy = $signed(y_st.ov);
		ovz = $signed(cur.ov);
		// least overlap, ties fall toward the later axis
		priority if (ovx < ovy && ovx < ovz) begin
			pa  = AXIS_X;
			sel = ovx;
			d   = x_st.dir;
		end else if (ovy < ovz) begin
			pa  = AXIS_Y;
			sel = ovy;
			d   = y_st.dir;
		end else begin
			pa  = AXIS_Z;
			sel = ovz;
			d   = cur.dir;
		end
		half    = sel >>> 1;
		neg_sel = (sel == Q_MIN) ? Q_MAX : -sel;

		res = '0;
		if (hit) begin
			res.hit       = 1'b1;
			res.push_axis = pa;
			if (dynamic) begin
				res.first_shift  = d ? -half : half;
				res.second_shift = d ? half : -half;
			end else begin
				res.first_shift  = d ? neg_sel : sel;
				res.second_shift = '0;
			end
			res.clear_first_velocity  = (pa == AXIS_Y);
			res.clear_second_velocity = (pa == AXIS_Y) && dynamic;
		end
	end

endmodule

// ----- rtl/aabb_pair_push_out.sv -----
// a z beat passes the input register and then the result register, which presents its result
// x and y beats update the pair state and give no result; axis code 3 is dropped
// throughput: one beat per cycle unless stalled, set by the single pass from input to result register
// a z beat stalls only while a finished result is still waiting on res_ready
// reset (arst_n low, asynchronous): pipeline empty, overlap and direction stores zero, overlap flag one
module aabb_pair_push_out (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  logic                          req_type,
	input  logic [1:0]                    axis,
	input  logic signed [apo_pkg::QW-1:0] first_min,
	input  logic signed [apo_pkg::QW-1:0] first_max,
	input  logic signed [apo_pkg::QW-1:0] first_pos,
	input  logic signed [apo_pkg::QW-1:0] second_min,
	input  logic signed [apo_pkg::QW-1:0] second_max,
	input  logic signed [apo_pkg::QW-1:0] second_pos,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic                          hit,
	output logic [1:0]                    push_axis,
	output logic signed [apo_pkg::QW-1:0] first_shift,
	output logic signed [apo_pkg::QW-1:0] second_shift,
	output logic                          clear_first_velocity,
	output logic                          clear_second_velocity
);
	import apo_pkg::*;

	// input register
	logic                 v_s1;
	logic                 type_s1;
	logic [1:0]           axis_s1;
	logic signed [QW-1:0] first_min_s1;
	logic signed [QW-1:0] first_max_s1;
	logic signed [QW-1:0] first_pos_s1;
	logic signed [QW-1:0] second_min_s1;
	logic signed [QW-1:0] second_max_s1;
	logic signed [QW-1:0] second_pos_s1;

	// pair state carried from the x and y beats
	apo_stored_t x_q;
	apo_stored_t y_q;
	logic        flag_q;

	apo_axis_t   ax;
	apo_result_t rs;
	apo_result_t res_q;
	logic        res_valid_q;
	logic        advance;

	// a beat leaves the input register unless it is a z beat blocked by a waiting result
	assign advance   = v_s1 && ((axis_s1 != AXIS_Z) || !res_valid_q || res_ready);
	assign req_ready = !v_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (req_valid && req_ready) begin
			v_s1 <= 1'b1;
		end else if (advance) begin
			v_s1 <= 1'b0;
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			type_s1       <= req_type;
			axis_s1       <= axis;
			first_min_s1  <= first_min;
			first_max_s1  <= first_max;
			first_pos_s1  <= first_pos;
			second_min_s1 <= second_min;
			second_max_s1 <= second_max;
			second_pos_s1 <= second_pos;
		end
	end

	apo_axis u_axis (
		.first_min  (first_min_s1),
		.first_max  (first_max_s1),
		.first_pos  (first_pos_s1),
		.second_min (second_min_s1),
		.second_max (second_max_s1),
		.second_pos (second_pos_s1),
		.res        (ax)
	);

	apo_resolve u_resolve (
		.dynamic (type_s1),
		.flag    (flag_q),
		.x_st    (x_q),
		.y_st    (y_q),
		.cur     (ax),
		.res     (rs)
	);

	// pair state: x restarts the pair, y folds in its test, z closes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q    <= '0;
			y_q    <= '0;
			flag_q <= 1'b1;
		end else if (advance) begin
			unique case (axis_s1)
				AXIS_X: begin
					x_q.ov  <= ax.ov;
					x_q.dir <= ax.dir;
					flag_q  <= ax.strict;
				end
				AXIS_Y: begin
					y_q.ov  <= ax.ov;
					y_q.dir <= ax.dir;
					flag_q  <= flag_q && ax.strict;
				end
				AXIS_Z: begin
					flag_q <= 1'b1;
				end
				default: begin
					// unused axis code leaves the pair untouched
				end
			endcase
		end
	end

	// result register, holds until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && (axis_s1 == AXIS_Z)) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && (axis_s1 == AXIS_Z)) begin
			res_q <= rs;
		end
	end

	assign res_valid             = res_valid_q;
	assign hit                   = res_q.hit;
	assign push_axis             = res_q.push_axis;
	assign first_shift           = res_q.first_shift;
	assign second_shift          = res_q.second_shift;
	assign clear_first_velocity  = res_q.clear_first_velocity;
	assign clear_second_velocity = res_q.clear_second_velocity;

endmodule

// ----- rtl/apo_checker.sv -----
module apo_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          res_valid,
	input logic                          res_ready,
	input logic                          hit,
	input logic [1:0]                    push_axis,
	input logic signed [apo_pkg::QW-1:0] first_shift,
	input logic signed [apo_pkg::QW-1:0] second_shift,
	input logic                          clear_first_velocity,
	input logic                          clear_second_velocity
);
	import apo_pkg::*;

	// with no result waiting the input side never stalls
	a_req_open: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !res_valid |-> req_ready)
		else $error("request beat stalled with no result waiting");

	// a stalled result beat keeps its payload
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(hit) && $stable(push_axis)
			&& $stable(first_shift) && $stable(second_shift))
		else $error("result beat changed while stalled");

	// a miss carries an all-zero payload
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !hit |-> push_axis == AXIS_X && first_shift == '0
			&& second_shift == '0 && !clear_first_velocity && !clear_second_velocity)
		else $error("miss with nonzero payload");

	// velocity clears follow a y push on a hit
	a_clear_y: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> clear_first_velocity == (hit && push_axis == AXIS_Y)
			&& (!clear_second_velocity || clear_first_velocity))
		else $error("velocity clear inconsistent with push axis");

	// a hit never reports the unused axis code
	a_axis_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && hit |-> push_axis == AXIS_X || push_axis == AXIS_Y
			|| push_axis == AXIS_Z)
		else $error("hit with bad push axis");

endmodule

bind aabb_pair_push_out apo_checker u_apo_checker (.*);
